### rtl/asm_pkg.sv
package asm_pkg;

	localparam int MAX_ENTRIES_DEF = 32;

	// task and system health codes
	localparam logic [1:0] ST_HEALTHY  = 2'd0;
	localparam logic [1:0] ST_DEGRADED = 2'd1;
	localparam logic [1:0] ST_CRITICAL = 2'd2;
	localparam logic [1:0] ST_FAILED   = 2'd3;

	// result event codes
	localparam logic [1:0] EV_FINAL  = 2'd0;
	localparam logic [1:0] EV_CHANGE = 2'd1;
	localparam logic [1:0] EV_CYCLE  = 2'd2;

	// input item kinds
	localparam logic [2:0] KIND_LOAD   = 3'd0;
	localparam logic [2:0] KIND_REPORT = 3'd1;
	localparam logic [2:0] KIND_TICK   = 3'd2;
	localparam logic [2:0] KIND_QUERY  = 3'd3;
	localparam logic [2:0] KIND_CLEAR  = 3'd4;

	// configuration register indexes
	localparam logic [1:0] REG_ENABLE   = 2'd0;
	localparam logic [1:0] REG_COUNT    = 2'd1;
	localparam logic [1:0] REG_INTERVAL = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD,
		S_EXEC,
		S_EV1,
		S_EV2,
		S_SW_RD,
		S_SW_EX,
		S_FINAL
	} state_t;

	typedef enum logic [1:0] {
		SW_SCAN,
		SW_REC,
		SW_CLR
	} sweep_t;

	typedef struct packed {
		logic [15:0] min_cycle;
		logic [15:0] max_cycle;
		logic [15:0] deadline;
		logic [7:0]  tolerance;
		logic        critical;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  health;
		logic [7:0]  strikes;
		logic [15:0] misses;
		logic [31:0] last_report;
		logic        seen;
	} rt_t;

	typedef struct packed {
		logic [1:0]  event_res;
		logic [4:0]  task_index;
		logic [1:0]  health_res;
		logic [31:0] cyc_ms;
		logic [15:0] miss_total;
		logic [1:0]  sys_health;
		logic        last;
	} out_t;

endpackage

### rtl/asm_ram.sv
module asm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/alive_supervision_monitor.sv
// Alive supervision watchdog for up to MAX_ENTRIES tasks. Task entries live in two
// RAMs (static window data and runtime counters) with a registered read port; every
// item is handled one at a time and in_stall stays high until its final status has
// been loaded into the output register. Load and query read the entry and then give
// their final status; a tick without a scan gives only its final status. A report
// that names a task in use always passes both event slots and then walks the used
// entries, one read and one update per entry, to recompute the system state. A
// supervision scan or a statistics reset walks the entries the same way. A held
// result waits while out_stall is high. Runtime entries read as cleared until first
// written after reset or after a change of monitor_enable. A configuration write is
// taken only while idle and no input item is offered.
module alive_supervision_monitor #(
	parameter int MAX_ENTRIES = asm_pkg::MAX_ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  kind,
	input  logic [4:0]  task_req,
	input  logic [15:0] min_cycle,
	input  logic [15:0] max_cycle,
	input  logic [15:0] deadline,
	input  logic [7:0]  tolerance_limit,
	input  logic        critical,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  event_res,
	output logic [4:0]  task_index,
	output logic [1:0]  health_res,
	output logic [31:0] cyc_ms,
	output logic [15:0] miss_total,
	output logic [1:0]  sys_health,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	import asm_pkg::*;

	localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW = $clog2(MAX_ENTRIES + 1);

	state_t state_q, state_nx;
	sweep_t mode_q;

	logic        en_q;
	logic [5:0]  tcount_q;
	logic [15:0] ivl_q;
	logic [31:0] now_q;
	logic [15:0] elapsed_q;
	logic [1:0]  overall_q;

	logic [2:0]  kind_q;
	logic [4:0]  t_q;
	cfg_t        load_q;

	logic [MAX_ENTRIES-1:0] rt_vld_q;
	logic        vld_rd_q;
	logic [CW-1:0] idx_q;
	logic [1:0]  worst_q;

	logic        ev1_q, ev2_q;
	logic [1:0]  ev1_st_q;
	logic [31:0] cyc_q;
	logic [4:0]  fin_idx_q;
	logic [1:0]  fin_st_q;
	logic [15:0] fin_miss_q;

	out_t        out_q;
	logic        out_valid_q;

	// RAM ports
	logic          rd_en;
	logic [AW-1:0] rd_addr, wr_addr;
	logic          cfg_we, rt_we;
	cfg_t          cfg_rdata;
	rt_t           rt_rdata, rt_rd, rt_wdata;

	logic in_acc, cfg_acc, can_emit;
	logic emit;
	out_t emit_d;

	// used count and index checks
	logic [8:0]  used9, req9;
	logic [CW-1:0] used;
	logic        req_valid, req_in_range;
	logic [15:0] ivl_eff, elapsed_inc;
	logic        scan_due;

	// entry compute
	logic [31:0] cyc;
	logic [7:0]  strikes_inc;
	logic [15:0] misses_inc;
	rt_t         rp_rec, sc_rec;
	logic        rp_ev1, rp_ev2;
	logic [1:0]  rp_ev1_st;
	logic        sc_due, sc_ev;
	logic [1:0]  sc_ns, h_new, worst_nx;
	logic        sweep_end;

	assign in_acc    = in_valid && !in_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign cfg_ready = (state_q == S_IDLE) && !in_valid;
	assign cfg_acc   = cfg_valid && cfg_ready;
	assign can_emit  = !out_valid_q || !out_stall;

	assign used9 = (tcount_q == 6'd0) ? 9'd1 :
	               ((9'(tcount_q) > 9'(MAX_ENTRIES)) ? 9'(MAX_ENTRIES) : 9'(tcount_q));
	assign used  = CW'(used9);
	assign req9  = 9'(task_req);
	assign req_valid    = en_q && (req9 < used9);
	assign req_in_range = req9 < 9'(MAX_ENTRIES);
	assign ivl_eff      = (ivl_q == 16'd0) ? 16'd1 : ivl_q;
	assign elapsed_inc  = (elapsed_q == 16'hFFFF) ? elapsed_q : elapsed_q + 16'd1;
	assign scan_due     = en_q && (elapsed_inc >= ivl_eff);
	assign sweep_end    = (CW'(idx_q + 1'b1) == used);

	// entry memories
	assign rd_en   = (state_q == S_RD) || (state_q == S_SW_RD);
	assign rd_addr = (state_q == S_SW_RD) ? AW'(idx_q) : AW'(t_q);

	asm_ram #(.WIDTH($bits(cfg_t)), .DEPTH(MAX_ENTRIES)) u_cfg_ram (
		.clk   (clk),
		.we    (cfg_we),
		.waddr (AW'(t_q)),
		.wdata (load_q),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (cfg_rdata)
	);

	asm_ram #(.WIDTH($bits(rt_t)), .DEPTH(MAX_ENTRIES)) u_rt_ram (
		.clk   (clk),
		.we    (rt_we),
		.waddr (wr_addr),
		.wdata (rt_wdata),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rt_rdata)
	);

	assign rt_rd = vld_rd_q ? rt_rdata : '0;

	// report: cycle window check
	assign cyc         = now_q - rt_rd.last_report;
	assign strikes_inc = (rt_rd.strikes == 8'hFF) ? rt_rd.strikes : rt_rd.strikes + 8'd1;
	assign misses_inc  = (rt_rd.misses == 16'hFFFF) ? rt_rd.misses : rt_rd.misses + 16'd1;

	always_comb begin
		rp_rec = rt_rd;
		rp_ev1 = 1'b0;
		rp_ev2 = 1'b0;
		rp_ev1_st = ST_HEALTHY;
		if (rt_rd.seen) begin
			if (cyc < 32'(cfg_rdata.min_cycle) || cyc > 32'(cfg_rdata.max_cycle)) begin
				rp_rec.strikes = strikes_inc;
				rp_ev2 = 1'b1;
				if (strikes_inc > cfg_rdata.tolerance) begin
					rp_rec.health = ST_DEGRADED;
					rp_ev1 = 1'b1;
					rp_ev1_st = ST_DEGRADED;
				end
			end else begin
				rp_rec.strikes = 8'd0;
				if (rt_rd.health != ST_HEALTHY) begin
					rp_rec.health = ST_HEALTHY;
					rp_ev1 = 1'b1;
				end
			end
		end
		rp_rec.last_report = now_q;
		rp_rec.seen = 1'b1;
	end

	// scan: deadline check of one entry
	always_comb begin
		sc_rec = rt_rd;
		sc_ev  = 1'b0;
		sc_ns  = cfg_rdata.critical ? ST_CRITICAL : ST_DEGRADED;
		sc_due = rt_rd.seen && (cyc >= 32'(cfg_rdata.deadline));
		if (sc_due) begin
			sc_rec.misses  = misses_inc;
			sc_rec.strikes = strikes_inc;
			if (strikes_inc > cfg_rdata.tolerance && rt_rd.health != sc_ns) begin
				sc_rec.health = sc_ns;
				sc_ev = 1'b1;
			end
		end
		h_new    = (mode_q == SW_SCAN) ? sc_rec.health : rt_rd.health;
		worst_nx = (cfg_rdata.critical && h_new > worst_q) ? h_new : worst_q;
	end

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					case (kind)
						KIND_LOAD:   state_nx = req_in_range ? S_RD : S_FINAL;
						KIND_REPORT: state_nx = req_valid ? S_RD : S_FINAL;
						KIND_QUERY:  state_nx = req_valid ? S_RD : S_FINAL;
						KIND_TICK:   state_nx = scan_due ? S_SW_RD : S_FINAL;
						KIND_CLEAR:  state_nx = en_q ? S_SW_RD : S_FINAL;
						default:     state_nx = S_FINAL;
					endcase
				end
			end
			S_RD:   state_nx = S_EXEC;
			S_EXEC: state_nx = (kind_q == KIND_REPORT) ? S_EV1 : S_FINAL;
			S_EV1: begin
				if (!ev1_q || can_emit) state_nx = S_EV2;
			end
			S_EV2: begin
				if (!ev2_q || can_emit) state_nx = S_SW_RD;
			end
			S_SW_RD: state_nx = S_SW_EX;
			S_SW_EX: begin
				if (!(mode_q == SW_SCAN && sc_ev && !can_emit)) begin
					state_nx = sweep_end ? S_FINAL : S_SW_RD;
				end
			end
			S_FINAL: begin
				if (can_emit) state_nx = S_IDLE;
			end
			default: state_nx = S_IDLE;
		endcase
	end

	// outputs: result emission and memory writes
	always_comb begin
		emit     = 1'b0;
		emit_d   = '0;
		cfg_we   = 1'b0;
		rt_we    = 1'b0;
		wr_addr  = AW'(t_q);
		rt_wdata = rp_rec;
		emit_d.sys_health = overall_q;
		case (state_q)
			S_EXEC: begin
				cfg_we = (kind_q == KIND_LOAD);
				rt_we  = (kind_q == KIND_REPORT);
			end
			S_EV1: begin
				emit = ev1_q && can_emit;
				emit_d.event_res  = EV_CHANGE;
				emit_d.task_index = t_q;
				emit_d.health_res = ev1_st_q;
				emit_d.miss_total = fin_miss_q;
			end
			S_EV2: begin
				emit = ev2_q && can_emit;
				emit_d.event_res  = EV_CYCLE;
				emit_d.task_index = t_q;
				emit_d.health_res = fin_st_q;
				emit_d.cyc_ms     = cyc_q;
				emit_d.miss_total = fin_miss_q;
			end
			S_SW_EX: begin
				wr_addr = AW'(idx_q);
				if (mode_q == SW_SCAN) begin
					rt_wdata = sc_rec;
					emit  = sc_ev && can_emit;
					rt_we = sc_due && (!sc_ev || can_emit);
				end else if (mode_q == SW_CLR) begin
					rt_wdata = rt_rd;
					rt_wdata.health  = ST_HEALTHY;
					rt_wdata.strikes = 8'd0;
					rt_wdata.misses  = 16'd0;
					rt_we = 1'b1;
				end
				emit_d.event_res  = EV_CHANGE;
				emit_d.task_index = 5'(idx_q);
				emit_d.health_res = sc_ns;
				emit_d.miss_total = sc_rec.misses;
			end
			S_FINAL: begin
				emit = can_emit;
				emit_d.event_res  = EV_FINAL;
				emit_d.task_index = fin_idx_q;
				emit_d.health_res = fin_st_q;
				emit_d.miss_total = fin_miss_q;
				emit_d.last       = 1'b1;
			end
			default: ;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// configuration, time base and system state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q      <= 1'b0;
			tcount_q  <= 6'd1;
			ivl_q     <= 16'd100;
			now_q     <= '0;
			elapsed_q <= '0;
			overall_q <= ST_HEALTHY;
			rt_vld_q  <= '0;
			vld_rd_q  <= 1'b0;
		end else begin
			if (cfg_acc) begin
				case (cfg_index)
					REG_ENABLE: begin
						if (cfg_data[0] != en_q) begin
							rt_vld_q  <= '0;
							elapsed_q <= '0;
							overall_q <= ST_HEALTHY;
						end
						en_q <= cfg_data[0];
					end
					REG_COUNT:    tcount_q <= cfg_data[5:0];
					REG_INTERVAL: ivl_q <= cfg_data;
					default: ;
				endcase
			end
			// advance time on tick
			if (in_acc && kind == KIND_TICK) begin
				now_q <= now_q + 32'd1;
				if (en_q) elapsed_q <= scan_due ? 16'd0 : elapsed_inc;
			end
			if (rd_en) vld_rd_q <= rt_vld_q[rd_addr];
			if (rt_we) rt_vld_q[wr_addr] <= 1'b1;
			// update system state at the end of a sweep
			if (state_q == S_SW_EX && state_nx != S_SW_EX && sweep_end) begin
				overall_q <= (mode_q == SW_CLR) ? ST_HEALTHY : worst_nx;
			end
		end
	end

	// item and sweep control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= SW_REC;
			idx_q   <= '0;
			worst_q <= ST_HEALTHY;
			ev1_q   <= 1'b0;
			ev2_q   <= 1'b0;
		end else begin
			if (in_acc) begin
				idx_q   <= '0;
				worst_q <= ST_HEALTHY;
				mode_q  <= (kind == KIND_CLEAR) ? SW_CLR : SW_SCAN;
			end
			if (state_q == S_EXEC) begin
				ev1_q  <= rp_ev1;
				ev2_q  <= rp_ev2;
				mode_q <= SW_REC;
			end
			if (state_q == S_SW_EX && state_nx != S_SW_EX) begin
				idx_q   <= CW'(idx_q + 1'b1);
				worst_q <= worst_nx;
			end
		end
	end

	// item payload and pending result fields
	always_ff @(posedge clk) begin
		if (in_acc) begin
			kind_q           <= kind;
			t_q              <= task_req;
			load_q.min_cycle <= min_cycle;
			load_q.max_cycle <= max_cycle;
			load_q.deadline  <= deadline;
			load_q.tolerance <= tolerance_limit;
			load_q.critical  <= critical;
			if (kind == KIND_LOAD || kind == KIND_REPORT || kind == KIND_QUERY) begin
				fin_idx_q <= task_req;
				fin_st_q  <= ST_FAILED;
			end else begin
				fin_idx_q <= 5'd0;
				fin_st_q  <= ST_HEALTHY;
			end
			fin_miss_q <= 16'd0;
		end
		if (state_q == S_EXEC) begin
			ev1_st_q <= rp_ev1_st;
			cyc_q    <= cyc;
			if (kind_q == KIND_REPORT) begin
				fin_st_q   <= rp_rec.health;
				fin_miss_q <= rp_rec.misses;
			end else begin
				fin_st_q   <= rt_rd.health;
				fin_miss_q <= rt_rd.misses;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) out_q <= emit_d;
	end

	assign out_valid  = out_valid_q;
	assign event_res  = out_q.event_res;
	assign task_index = out_q.task_index;
	assign health_res = out_q.health_res;
	assign cyc_ms     = out_q.cyc_ms;
	assign miss_total = out_q.miss_total;
	assign sys_health = out_q.sys_health;
	assign last       = out_q.last;

endmodule
